// File: rtl/core/sla_pkg.sv
// ----------------------------------------------------------------------------
// sla_pkg: shared types and constants for the look angle core
// Fixed-point constants, lane indexes, sideband structs and the CORDIC
// arctangent table in binary angle units (2^32 units per turn).
// ----------------------------------------------------------------------------
package sla_pkg;

  localparam int FULL_MD     = 360000;
  localparam int HALF_MD     = 180000;
  localparam int QUARTER_MD  = 90000;
  localparam int UNWRAP_MD   = 270000;
  localparam int LOW_LONG_MD = 91000;

  // datapath width of the cordic units
  localparam int CW = 34;

  localparam int LANES      = 2;
  localparam int LANE_DELTA = 0;
  localparam int LANE_LAT   = 1;
  localparam int LANE_AZ    = 0;
  localparam int LANE_EL    = 1;

  localparam logic signed [CW-1:0] GAIN_INV_Q30 = CW'(64'sd652032874);
  localparam logic signed [CW-1:0] RATIO_Q30    = CW'(64'sd162424926);
  localparam logic signed [CW-1:0] QUARTER_BIN  = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] HALF_BIN     = CW'(64'sd2147483648);

  // millidegree to binary angle: b = 11930*r + floor((5228*r + 5625) / 11250)
  localparam logic [31:0] TURN_MUL    = 32'd11930;
  localparam logic [12:0] FRAC_MUL    = 13'd5228;
  localparam logic [30:0] FRAC_ADD    = 31'd5625;
  localparam logic [32:0] DIV_N       = 33'd11250;
  localparam logic [30:0] RECIP_M     = 31'd1563749871;
  localparam int          RECIP_SHIFT = 44;

  localparam logic [63:0] ONE_Q60  = 64'h1000_0000_0000_0000;
  localparam int          SQ_STEPS = 31;

  localparam logic [8:0] POL_VERT  = 9'd45;
  localparam logic [8:0] POL_HORIZ = 9'd315;

  typedef struct packed {
    logic degen;
    logic north;
    logic vert;
  } side_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] xa;
    logic signed [31:0] ys;
    side_t              sb;
  } sq_side_t;

  function automatic logic signed [CW-1:0] atan_val(input int idx);
    logic signed [CW-1:0] v;
    unique case (idx)
      0:  v = CW'(64'h20000000);
      1:  v = CW'(64'h12E4051E);
      2:  v = CW'(64'h09FB385B);
      3:  v = CW'(64'h051111D4);
      4:  v = CW'(64'h028B0D43);
      5:  v = CW'(64'h0145D7E1);
      6:  v = CW'(64'h00A2F61E);
      7:  v = CW'(64'h00517C55);
      8:  v = CW'(64'h0028BE53);
      9:  v = CW'(64'h00145F2F);
      10: v = CW'(64'h000A2F98);
      11: v = CW'(64'h000517CC);
      12: v = CW'(64'h00028BE6);
      13: v = CW'(64'h000145F3);
      14: v = CW'(64'h0000A2FA);
      15: v = CW'(64'h0000517D);
      16: v = CW'(64'h000028BE);
      17: v = CW'(64'h0000145F);
      18: v = CW'(64'h00000A30);
      19: v = CW'(64'h00000518);
      20: v = CW'(64'h0000028C);
      21: v = CW'(64'h00000146);
      22: v = CW'(64'h000000A3);
      23: v = CW'(64'h00000051);
      24: v = CW'(64'h00000029);
      25: v = CW'(64'h00000014);
      26: v = CW'(64'h0000000A);
      27: v = CW'(64'h00000005);
      28: v = CW'(64'h00000003);
      29: v = CW'(64'h00000001);
      30: v = CW'(64'h00000001);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/sla_cordic_rot.sv
// ----------------------------------------------------------------------------
// sla_cordic_rot: pipelined rotation-mode cordic, sine and cosine
// Two lanes share the pipeline; angles are folded into [-90,90] degrees in
// the first stage and folded results are negated in the output stage.
// ----------------------------------------------------------------------------
module sla_cordic_rot #(
  parameter int STAGES = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [31:0]    in_angle [sla_pkg::LANES],
  input  sla_pkg::side_t        in_side,
  output logic                  out_valid,
  output logic signed [31:0]    out_sin [sla_pkg::LANES],
  output logic signed [31:0]    out_cos [sla_pkg::LANES],
  output sla_pkg::side_t        out_side
);

  localparam int W = sla_pkg::CW;
  localparam int L = sla_pkg::LANES;

  logic signed [W-1:0] x_r   [STAGES+1][L];
  logic signed [W-1:0] x_nxt [STAGES+1][L];
  logic signed [W-1:0] y_r   [STAGES+1][L];
  logic signed [W-1:0] y_nxt [STAGES+1][L];
  logic signed [W-1:0] a_r   [STAGES+1][L];
  logic signed [W-1:0] a_nxt [STAGES+1][L];
  logic [L-1:0]        flip_r   [STAGES+1];
  logic [L-1:0]        flip_nxt [STAGES+1];
  logic [STAGES:0]     v_r;
  sla_pkg::side_t      sb_r [STAGES+1];

  logic                out_valid_r;
  logic signed [31:0]  sin_r [L];
  logic signed [31:0]  cos_r [L];
  sla_pkg::side_t      out_side_r;

  always_comb begin
    logic signed [W-1:0] a_in;
    for (int l = 0; l < L; l++) begin
      a_in           = W'(in_angle[l]);
      x_nxt[0][l]    = sla_pkg::GAIN_INV_Q30;
      y_nxt[0][l]    = '0;
      a_nxt[0][l]    = a_in;
      flip_nxt[0][l] = 1'b0;
      // fold into the right half plane
      if (a_in > sla_pkg::QUARTER_BIN) begin
        a_nxt[0][l]    = a_in - sla_pkg::HALF_BIN;
        flip_nxt[0][l] = 1'b1;
      end else if (a_in < -sla_pkg::QUARTER_BIN) begin
        a_nxt[0][l]    = a_in + sla_pkg::HALF_BIN;
        flip_nxt[0][l] = 1'b1;
      end
    end
    for (int s = 0; s < STAGES; s++) begin
      flip_nxt[s+1] = flip_r[s];
      for (int l = 0; l < L; l++) begin
        if (a_r[s][l] >= 0) begin
          x_nxt[s+1][l] = x_r[s][l] - (y_r[s][l] >>> s);
          y_nxt[s+1][l] = y_r[s][l] + (x_r[s][l] >>> s);
          a_nxt[s+1][l] = a_r[s][l] - sla_pkg::atan_val(s);
        end else begin
          x_nxt[s+1][l] = x_r[s][l] + (y_r[s][l] >>> s);
          y_nxt[s+1][l] = y_r[s][l] - (x_r[s][l] >>> s);
          a_nxt[s+1][l] = a_r[s][l] + sla_pkg::atan_val(s);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[STAGES-1:0], in_valid};
      out_valid_r <= v_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      a_r    <= a_nxt;
      flip_r <= flip_nxt;
      sb_r[0] <= in_side;
      for (int s = 1; s <= STAGES; s++) begin
        sb_r[s] <= sb_r[s-1];
      end
      out_side_r <= sb_r[STAGES];
      for (int l = 0; l < L; l++) begin
        sin_r[l] <= flip_r[STAGES][l] ? 32'(-y_r[STAGES][l]) : 32'(y_r[STAGES][l]);
        cos_r[l] <= flip_r[STAGES][l] ? 32'(-x_r[STAGES][l]) : 32'(x_r[STAGES][l]);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_sin   = sin_r;
  assign out_cos   = cos_r;
  assign out_side  = out_side_r;

endmodule

// File: rtl/core/sla_isqrt.sv
// ----------------------------------------------------------------------------
// sla_isqrt: pipelined integer square root
// One result bit per stage, restoring method on the running remainder;
// gives floor(sqrt(v)) for a 61-bit radicand.
// ----------------------------------------------------------------------------
module sla_isqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [60:0]       in_rad,
  input  sla_pkg::sq_side_t in_side,
  output logic              out_valid,
  output logic [30:0]       out_root,
  output sla_pkg::sq_side_t out_side
);

  localparam int SQ = sla_pkg::SQ_STEPS;
  localparam int RW = 2 * SQ;

  logic [RW-1:0]     rem_r   [SQ];
  logic [RW-1:0]     rem_nxt [SQ];
  logic [SQ-1:0]     q_r     [SQ];
  logic [SQ-1:0]     q_nxt   [SQ];
  logic [SQ-1:0]     v_r;
  sla_pkg::sq_side_t sb_r [SQ];

  always_comb begin
    logic [RW-1:0] src_rem;
    logic [RW-1:0] trial;
    logic [SQ-1:0] src_q;
    for (int s = 0; s < SQ; s++) begin
      if (s == 0) begin
        src_rem = RW'(in_rad);
        src_q   = '0;
      end else begin
        src_rem = rem_r[s-1];
        src_q   = q_r[s-1];
      end
      // (q + 2^k)^2 - q^2
      trial = (RW'(src_q) << (SQ - s)) + (RW'(1) << (2 * (SQ - 1 - s)));
      if (src_rem >= trial) begin
        rem_nxt[s] = src_rem - trial;
        q_nxt[s]   = src_q | (SQ'(1) << (SQ - 1 - s));
      end else begin
        rem_nxt[s] = src_rem;
        q_nxt[s]   = src_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SQ-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r   <= rem_nxt;
      q_r     <= q_nxt;
      sb_r[0] <= in_side;
      for (int s = 1; s < SQ; s++) begin
        sb_r[s] <= sb_r[s-1];
      end
    end
  end

  assign out_valid = v_r[SQ-1];
  assign out_root  = q_r[SQ-1];
  assign out_side  = sb_r[SQ-1];

endmodule

// File: rtl/core/sla_cordic_vec.sv
// ----------------------------------------------------------------------------
// sla_cordic_vec: pipelined vectoring-mode cordic, atan2 for x >= 0
// Two lanes share the pipeline; the angle comes out in binary units.
// ----------------------------------------------------------------------------
module sla_cordic_vec #(
  parameter int STAGES = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [sla_pkg::CW-1:0] in_y [sla_pkg::LANES],
  input  logic signed [sla_pkg::CW-1:0] in_x [sla_pkg::LANES],
  input  sla_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic signed [sla_pkg::CW-1:0] out_z [sla_pkg::LANES],
  output sla_pkg::side_t               out_side
);

  localparam int W = sla_pkg::CW;
  localparam int L = sla_pkg::LANES;

  logic signed [W-1:0] x_r   [STAGES][L];
  logic signed [W-1:0] x_nxt [STAGES][L];
  logic signed [W-1:0] y_r   [STAGES][L];
  logic signed [W-1:0] y_nxt [STAGES][L];
  logic signed [W-1:0] z_r   [STAGES][L];
  logic signed [W-1:0] z_nxt [STAGES][L];
  logic [STAGES-1:0]   v_r;
  sla_pkg::side_t      sb_r [STAGES];

  always_comb begin
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic signed [W-1:0] zs;
    for (int s = 0; s < STAGES; s++) begin
      for (int l = 0; l < L; l++) begin
        if (s == 0) begin
          xs = in_x[l];
          ys = in_y[l];
          zs = '0;
        end else begin
          xs = x_r[s-1][l];
          ys = y_r[s-1][l];
          zs = z_r[s-1][l];
        end
        if (ys >= 0) begin
          x_nxt[s][l] = xs + (ys >>> s);
          y_nxt[s][l] = ys - (xs >>> s);
          z_nxt[s][l] = zs + sla_pkg::atan_val(s);
        end else begin
          x_nxt[s][l] = xs - (ys >>> s);
          y_nxt[s][l] = ys + (xs >>> s);
          z_nxt[s][l] = zs - sla_pkg::atan_val(s);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      sb_r[0] <= in_side;
      for (int s = 1; s < STAGES; s++) begin
        sb_r[s] <= sb_r[s-1];
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_z     = z_r[STAGES-1];
  assign out_side  = sb_r[STAGES-1];

endmodule

// File: rtl/core/satellite_look_angle_core.sv
// ----------------------------------------------------------------------------
// satellite_look_angle_core: geostationary antenna look angle pipeline
// Azimuth, elevation and polarization for one station/satellite pair.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes station longitude/latitude, satellite longitude,
//   hemisphere flags and the polarization mode; the result channel returns
//   azimuth, elevation (millidegrees), polarization (degrees) and a status
//   bit flagging degenerate geometry (equator or delta at 90 or 270 degrees).
//   Both channels are valid/ready; one transfer per cycle is sustained
//   while out_ready stays high. The path runs through four angle conversion
//   stages, the sin/cos cordic, four multiply stages, a 31-stage square
//   root, an operand register, the atan2 cordic and two scaling stages.
//   Throughput is one item per cycle while results are taken, set by the
//   fully pipelined cordic and square root units.
//   The pipeline advances whenever the output register is empty or being
//   taken; when the receiver stalls with a result held, every stage holds
//   and in_ready drops, so nothing is lost or repeated.
//   Synchronous reset clears all valid bits; no results are pending after it.
// ----------------------------------------------------------------------------
module satellite_look_angle_core #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [17:0]        in_station_long,
  input  logic               in_station_east,
  input  logic [16:0]        in_station_lat,
  input  logic               in_station_north,
  input  logic [17:0]        in_sat_long,
  input  logic               in_sat_east,
  input  logic               in_vertical_pol,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [18:0]        out_azimuth,
  output logic signed [17:0] out_elevation,
  output logic [8:0]         out_polarization,
  output logic               out_status
);

  localparam int W = sla_pkg::CW;
  localparam int L = sla_pkg::LANES;

  localparam logic signed [21:0] FULL_S  = 22'(sla_pkg::FULL_MD);
  localparam logic signed [21:0] UNW_S   = 22'(sla_pkg::UNWRAP_MD);
  localparam logic signed [21:0] LOW_S   = 22'(sla_pkg::LOW_LONG_MD);
  localparam logic signed [21:0] Q1_S    = 22'(sla_pkg::QUARTER_MD);
  localparam logic signed [21:0] Q3_S    = 22'(3 * sla_pkg::QUARTER_MD);
  localparam logic signed [21:0] Q5_S    = 22'(5 * sla_pkg::QUARTER_MD);
  localparam logic signed [21:0] Q7_S    = 22'(7 * sla_pkg::QUARTER_MD);
  localparam logic signed [21:0] Q90_E   = 22'(sla_pkg::QUARTER_MD);
  localparam logic signed [19:0] MD_MUL  = 20'(sla_pkg::FULL_MD);
  localparam logic signed [53:0] RND_BIN = 54'sd2147483648;
  localparam logic signed [19:0] HALF_20 = 20'(sla_pkg::HALF_MD);
  localparam logic signed [19:0] FULL_20 = 20'(sla_pkg::FULL_MD);

  logic out_valid_r;
  logic en;
  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  // ---------------- stage 1: unwrap, delta, reduce mod 360 ----------------
  logic                 s1_valid_r;
  logic [18:0]          s1_rd_r, s1_rd_nxt;
  logic [16:0]          s1_lat_r;
  sla_pkg::side_t       s1_sb_r, s1_sb_nxt;

  always_comb begin
    logic signed [21:0] slong_w;
    logic signed [21:0] star_w;
    logic signed [21:0] delta_w;
    logic signed [21:0] t_w;
    slong_w = in_station_east ? 22'(in_station_long) : FULL_S - 22'(in_station_long);
    star_w  = in_sat_east ? 22'(in_sat_long) : FULL_S - 22'(in_sat_long);
    // unwrap across the 0/360 seam
    if ((slong_w - star_w > UNW_S) || (star_w - slong_w > UNW_S)) begin
      if (slong_w < LOW_S) begin
        slong_w = slong_w + FULL_S;
      end else begin
        star_w = star_w + FULL_S;
      end
    end
    delta_w = star_w - slong_w;
    t_w     = delta_w + (FULL_S <<< 1);
    if (t_w >= (FULL_S <<< 2)) begin
      s1_rd_nxt = 19'(t_w - (FULL_S <<< 2));
    end else if (t_w >= 3 * FULL_S) begin
      s1_rd_nxt = 19'(t_w - 3 * FULL_S);
    end else if (t_w >= (FULL_S <<< 1)) begin
      s1_rd_nxt = 19'(t_w - (FULL_S <<< 1));
    end else if (t_w >= FULL_S) begin
      s1_rd_nxt = 19'(t_w - FULL_S);
    end else begin
      s1_rd_nxt = 19'(t_w);
    end
    s1_sb_nxt.degen = (in_station_lat == '0) ||
                      (delta_w == Q1_S) || (delta_w == -Q1_S) ||
                      (delta_w == Q3_S) || (delta_w == -Q3_S) ||
                      (delta_w == Q5_S) || (delta_w == -Q5_S) ||
                      (delta_w == Q7_S) || (delta_w == -Q7_S);
    s1_sb_nxt.north = in_station_north;
    s1_sb_nxt.vert  = in_vertical_pol;
  end

  // ---------------- stage 2: n = 5228*r + 5625 ----------------
  logic                 s2_valid_r;
  logic [30:0]          s2_nd_r, s2_nl_r;
  logic [18:0]          s2_rd_r;
  logic [16:0]          s2_lat_r;
  sla_pkg::side_t       s2_sb_r;

  // ---------------- stage 3: reciprocal multiply ----------------
  logic                 s3_valid_r;
  logic [61:0]          s3_pd_r, s3_pl_r;
  logic [30:0]          s3_nd_r, s3_nl_r;
  logic [18:0]          s3_rd_r;
  logic [16:0]          s3_lat_r;
  sla_pkg::side_t       s3_sb_r;

  // ---------------- stage 4: correct quotient, binary angle ----------------
  logic                 s4_valid_r;
  logic signed [31:0]   s4_ad_r, s4_al_r, s4_ad_nxt, s4_al_nxt;
  sla_pkg::side_t       s4_sb_r;

  always_comb begin
    logic [17:0] qd;
    logic [17:0] ql;
    qd = s3_pd_r[sla_pkg::RECIP_SHIFT +: 18];
    ql = s3_pl_r[sla_pkg::RECIP_SHIFT +: 18];
    if (33'(qd) * sla_pkg::DIV_N > 33'(s3_nd_r)) begin
      qd = qd - 18'd1;
    end
    if (33'(ql) * sla_pkg::DIV_N > 33'(s3_nl_r)) begin
      ql = ql - 18'd1;
    end
    s4_ad_nxt = $signed(32'(32'(s3_rd_r) * sla_pkg::TURN_MUL) + 32'(qd));
    s4_al_nxt = $signed(32'(32'(s3_lat_r) * sla_pkg::TURN_MUL) + 32'(ql));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rd_r  <= s1_rd_nxt;
      s1_lat_r <= in_station_lat;
      s1_sb_r  <= s1_sb_nxt;
      s2_nd_r  <= 31'(s1_rd_r * sla_pkg::FRAC_MUL) + sla_pkg::FRAC_ADD;
      s2_nl_r  <= 31'(s1_lat_r * sla_pkg::FRAC_MUL) + sla_pkg::FRAC_ADD;
      s2_rd_r  <= s1_rd_r;
      s2_lat_r <= s1_lat_r;
      s2_sb_r  <= s1_sb_r;
      s3_pd_r  <= s2_nd_r * sla_pkg::RECIP_M;
      s3_pl_r  <= s2_nl_r * sla_pkg::RECIP_M;
      s3_nd_r  <= s2_nd_r;
      s3_nl_r  <= s2_nl_r;
      s3_rd_r  <= s2_rd_r;
      s3_lat_r <= s2_lat_r;
      s3_sb_r  <= s2_sb_r;
      s4_ad_r  <= s4_ad_nxt;
      s4_al_r  <= s4_al_nxt;
      s4_sb_r  <= s3_sb_r;
    end
  end

  // ---------------- sin/cos of delta and latitude ----------------
  logic signed [31:0] rot_ang [L];
  logic signed [31:0] rot_sin [L];
  logic signed [31:0] rot_cos [L];
  logic               rot_valid;
  sla_pkg::side_t     rot_sb;

  assign rot_ang[sla_pkg::LANE_DELTA] = s4_ad_r;
  assign rot_ang[sla_pkg::LANE_LAT]   = s4_al_r;

  sla_cordic_rot #(
    .STAGES(CORDIC_STAGES)
  ) u_rot (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s4_valid_r),
    .in_angle (rot_ang),
    .in_side  (s4_sb_r),
    .out_valid(rot_valid),
    .out_sin  (rot_sin),
    .out_cos  (rot_cos),
    .out_side (rot_sb)
  );

  // ---------------- multiply stages ----------------
  logic               m1_valid_r, m2_valid_r, m3_valid_r, m4_valid_r;
  logic signed [63:0] m1_paz_r, m1_pc_r, m1_paz_nxt;
  logic signed [31:0] m1_ys_r, m1_ys_nxt;
  sla_pkg::side_t     m1_sb_r, m2_sb_r, m3_sb_r;
  logic signed [31:0] m2_xa_r, m2_c_r, m2_ys_r, m2_xa_nxt;
  logic [63:0]        m3_cc_r;
  logic signed [31:0] m3_xa_r, m3_c_r, m3_ys_r;
  logic [60:0]        m4_rad_r;
  sla_pkg::sq_side_t  m4_side_r;

  always_comb begin
    logic signed [31:0] xs;
    // sign flip on both keeps the tangent
    if (rot_cos[sla_pkg::LANE_DELTA] < 0) begin
      xs        = -rot_cos[sla_pkg::LANE_DELTA];
      m1_ys_nxt = -rot_sin[sla_pkg::LANE_DELTA];
    end else begin
      xs        = rot_cos[sla_pkg::LANE_DELTA];
      m1_ys_nxt = rot_sin[sla_pkg::LANE_DELTA];
    end
    m1_paz_nxt = xs * rot_sin[sla_pkg::LANE_LAT];
  end

  always_comb begin
    if (m1_paz_r < 0) begin
      m2_xa_nxt = '0;
    end else begin
      m2_xa_nxt = 32'(m1_paz_r >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
      m3_valid_r <= 1'b0;
      m4_valid_r <= 1'b0;
    end else if (en) begin
      m1_valid_r <= rot_valid;
      m2_valid_r <= m1_valid_r;
      m3_valid_r <= m2_valid_r;
      m4_valid_r <= m3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_paz_r <= m1_paz_nxt;
      m1_pc_r  <= rot_cos[sla_pkg::LANE_DELTA] * rot_cos[sla_pkg::LANE_LAT];
      m1_ys_r  <= m1_ys_nxt;
      m1_sb_r  <= rot_sb;
      m2_xa_r  <= m2_xa_nxt;
      m2_c_r   <= 32'(m1_pc_r >>> 30);
      m2_ys_r  <= m1_ys_r;
      m2_sb_r  <= m1_sb_r;
      m3_cc_r  <= m2_c_r * m2_c_r;
      m3_xa_r  <= m2_xa_r;
      m3_c_r   <= m2_c_r;
      m3_ys_r  <= m2_ys_r;
      m3_sb_r  <= m2_sb_r;
      m4_rad_r <= (m3_cc_r > sla_pkg::ONE_Q60) ? '0 : 61'(sla_pkg::ONE_Q60 - m3_cc_r);
      m4_side_r.c  <= m3_c_r;
      m4_side_r.xa <= m3_xa_r;
      m4_side_r.ys <= m3_ys_r;
      m4_side_r.sb <= m3_sb_r;
    end
  end

  // ---------------- square root ----------------
  logic              sq_valid;
  logic [30:0]       sq_root;
  sla_pkg::sq_side_t sq_side;

  sla_isqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (m4_valid_r),
    .in_rad   (m4_rad_r),
    .in_side  (m4_side_r),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // ---------------- atan2 operands ----------------
  logic                p_valid_r;
  logic signed [W-1:0] p_y_r [L];
  logic signed [W-1:0] p_x_r [L];
  sla_pkg::side_t      p_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_y_r[sla_pkg::LANE_AZ] <= W'(sq_side.ys);
      p_x_r[sla_pkg::LANE_AZ] <= W'(sq_side.xa);
      p_y_r[sla_pkg::LANE_EL] <= W'(sq_side.c) - sla_pkg::RATIO_Q30;
      p_x_r[sla_pkg::LANE_EL] <= W'(sq_root);
      p_sb_r                  <= sq_side.sb;
    end
  end

  logic                vec_valid;
  logic signed [W-1:0] vec_z [L];
  sla_pkg::side_t      vec_sb;

  sla_cordic_vec #(
    .STAGES(CORDIC_STAGES)
  ) u_vec (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (p_valid_r),
    .in_y     (p_y_r),
    .in_x     (p_x_r),
    .in_side  (p_sb_r),
    .out_valid(vec_valid),
    .out_z    (vec_z),
    .out_side (vec_sb)
  );

  // ---------------- back to millidegrees, output register ----------------
  logic                b1_valid_r;
  logic signed [W+19:0] b1_paz_r, b1_pel_r;
  sla_pkg::side_t      b1_sb_r;

  logic [18:0]         out_az_r, out_az_nxt;
  logic signed [17:0]  out_el_r, out_el_nxt;
  logic [8:0]          out_pol_r;
  logic                out_st_r;

  always_comb begin
    logic signed [W+19:0] sum_az;
    logic signed [W+19:0] sum_el;
    logic signed [21:0]   md_az;
    logic signed [21:0]   md_el;
    logic signed [19:0]   cl_az;
    logic signed [19:0]   az_s;
    sum_az = b1_paz_r + RND_BIN;
    sum_el = b1_pel_r + RND_BIN;
    md_az  = $signed(sum_az[W+19:32]);
    md_el  = $signed(sum_el[W+19:32]);
    if (md_az > Q90_E) begin
      cl_az = 20'(Q90_E);
    end else if (md_az < -Q90_E) begin
      cl_az = -20'(Q90_E);
    end else begin
      cl_az = 20'(md_az);
    end
    if (md_el > Q90_E) begin
      out_el_nxt = 18'(Q90_E);
    end else if (md_el < -Q90_E) begin
      out_el_nxt = -18'(Q90_E);
    end else begin
      out_el_nxt = 18'(md_el);
    end
    az_s = HALF_20 - cl_az;
    if (b1_sb_r.degen) begin
      az_s = HALF_20;
    end else if (!b1_sb_r.north) begin
      az_s = FULL_20 - az_s;
    end
    out_az_nxt = 19'(az_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b1_valid_r  <= vec_valid;
      out_valid_r <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_paz_r  <= vec_z[sla_pkg::LANE_AZ] * MD_MUL;
      b1_pel_r  <= vec_z[sla_pkg::LANE_EL] * MD_MUL;
      b1_sb_r   <= vec_sb;
      out_az_r  <= out_az_nxt;
      out_el_r  <= out_el_nxt;
      out_pol_r <= b1_sb_r.vert ? sla_pkg::POL_VERT : sla_pkg::POL_HORIZ;
      out_st_r  <= b1_sb_r.degen;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_azimuth      = out_az_r;
  assign out_elevation    = out_el_r;
  assign out_polarization = out_pol_r;
  assign out_status       = out_st_r;

  // degenerate geometry always points due south/north at 180 degrees
  a_degen_az: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_azimuth == 19'd180000)
    else $error("degenerate result with azimuth other than 180000");

  a_az_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_azimuth >= 19'd90000 && out_azimuth <= 19'd270000)
    else $error("azimuth outside the reachable range");

  a_el_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_elevation <= 18'sd90000 && out_elevation >= -18'sd90000)
    else $error("elevation beyond clamp");

  a_pol_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_polarization == 9'd45 || out_polarization == 9'd315)
    else $error("bad polarization angle");

  // a held result keeps the whole pipe frozen
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(b1_paz_r) && $stable(b1_valid_r))
    else $error("pipeline moved during output stall");

endmodule

// File: bench/satellite_look_angle_core_test.sv
// ----------------------------------------------------------------------------
// satellite_look_angle_core_test: self-checking bench for the look angle core
// A directed table of coordinate sets and then random sets drive the input
// channel; results are checked field by field against a bit-exact fixed-point
// look angle calculation held in the bench, or typed-in values on fixed rows.
// ----------------------------------------------------------------------------
module satellite_look_angle_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  STAGES    = 24;
  localparam int  LATENCY   = 2 * STAGES + 44;
  localparam int  MAX_CYCLES = 400000;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint TURN    = 64'sd4294967296;
  localparam longint HALF_T  = 64'sd2147483648;
  localparam longint QUART_T = 64'sd1073741824;
  localparam longint GAIN_Q30  = 64'sd652032874;
  localparam longint ORBIT_Q30 = 64'sd162424926;

  typedef struct {
    logic [17:0] station_long;
    logic        station_east;
    logic [16:0] station_lat;
    logic        station_north;
    logic [17:0] sat_long;
    logic        sat_east;
    logic        vertical_pol;
  } coord_t;

  typedef struct {
    logic [18:0]        azimuth;
    logic signed [17:0] elevation;
    logic [8:0]         polarization;
    logic               status;
  } look_t;

  typedef struct {
    coord_t      c;
    bit          fixed;   // azimuth, polarization and status typed in
    logic [18:0] az;
    logic [8:0]  pol;
    logic        st;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [17:0] in_station_long = '0;
  logic        in_station_east = 1'b0;
  logic [16:0] in_station_lat = '0;
  logic        in_station_north = 1'b0;
  logic [17:0] in_sat_long = '0;
  logic        in_sat_east = 1'b0;
  logic        in_vertical_pol = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [18:0] out_azimuth;
  logic signed [17:0] out_elevation;
  logic [8:0]  out_polarization;
  logic        out_status;

  look_t  pending_looks[$];
  int     mismatches = 0;
  int     cycles = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  longint atan_lut[32];

  satellite_look_angle_core #(.CORDIC_STAGES(STAGES)) dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------- fixed-point look angle calculation ----------------
  function automatic longint wrap_pos(longint v, longint m);
    longint r;
    r = v % m;
    return (r < 0) ? r + m : r;
  endfunction

  function automatic longint mdeg_to_bin(longint md);
    longint r, b;
    r = wrap_pos(md, sla_pkg::FULL_MD);
    b = (r * TURN + sla_pkg::HALF_MD) / sla_pkg::FULL_MD;
    if (b >= TURN) b -= TURN;
    if (b >= HALF_T) b -= TURN;
    return b;
  endfunction

  function automatic longint bin_to_mdeg(longint z);
    return (z * sla_pkg::FULL_MD + HALF_T) >>> 32;
  endfunction

  function automatic void rotate_sincos(longint a, output longint s, output longint c);
    longint x, y, t;
    bit flip;
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    if (a > QUART_T) begin
      a -= HALF_T;
      flip = 1;
    end else if (a < -QUART_T) begin
      a += HALF_T;
      flip = 1;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (a >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); a -= atan_lut[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); a += atan_lut[i];
      end
      x = t;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint vector_atan(longint y, longint x);
    longint z, t;
    z = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (y >= 0) begin
        t = x + (y >>> i); y = y - (x >>> i); z += atan_lut[i];
      end else begin
        t = x - (y >>> i); y = y + (x >>> i); z -= atan_lut[i];
      end
      x = t;
    end
    return z;
  endfunction

  function automatic longint root64(bit [63:0] v);
    bit [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint clamp_quarter(longint v);
    if (v > sla_pkg::QUARTER_MD) return sla_pkg::QUARTER_MD;
    if (v < -sla_pkg::QUARTER_MD) return -sla_pkg::QUARTER_MD;
    return v;
  endfunction

  function automatic look_t predict_look(coord_t ci);
    longint st_lon, sat_lon, lat, delta, sd, cd, sl, cl, ys, xs, xa, az, c, rad, el;
    bit degen;
    look_t r;
    st_lon = longint'(ci.station_long);
    sat_lon = longint'(ci.sat_long);
    lat = longint'(ci.station_lat);
    if (!ci.station_east) st_lon = sla_pkg::FULL_MD - st_lon;
    if (!ci.sat_east) sat_lon = sla_pkg::FULL_MD - sat_lon;
    // unwrap across the 0/360 seam
    if ((st_lon - sat_lon > sla_pkg::UNWRAP_MD) || (sat_lon - st_lon > sla_pkg::UNWRAP_MD)) begin
      if (st_lon < sla_pkg::LOW_LONG_MD) st_lon += sla_pkg::FULL_MD;
      else sat_lon += sla_pkg::FULL_MD;
    end
    delta = sat_lon - st_lon;
    degen = (lat == 0) || (wrap_pos(delta, sla_pkg::HALF_MD) == sla_pkg::QUARTER_MD);
    rotate_sincos(mdeg_to_bin(delta), sd, cd);
    rotate_sincos(mdeg_to_bin(lat), sl, cl);
    if (degen) begin
      az = sla_pkg::HALF_MD;
    end else begin
      ys = sd;
      xs = cd;
      if (xs < 0) begin
        xs = -xs;
        ys = -ys;
      end
      xa = (xs * sl) >>> 30;
      if (xa < 0) xa = 0;
      az = sla_pkg::HALF_MD - clamp_quarter(bin_to_mdeg(vector_atan(ys, xa)));
      if (!ci.station_north) az = sla_pkg::FULL_MD - az;
    end
    c = (cd * cl) >>> 30;
    rad = ONE_Q30 * ONE_Q30 - c * c;
    if (rad < 0) rad = 0;
    el = clamp_quarter(bin_to_mdeg(vector_atan(c - ORBIT_Q30, root64(rad))));
    r.azimuth = az[18:0];
    r.elevation = el[17:0];
    r.polarization = ci.vertical_pol ? sla_pkg::POL_VERT : sla_pkg::POL_HORIZ;
    r.status = degen;
    return r;
  endfunction

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    look_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_looks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer az=%0d", out_azimuth);
      end else begin
        want = pending_looks.pop_front();
        if (out_azimuth !== want.azimuth || out_elevation !== want.elevation ||
            out_polarization !== want.polarization || out_status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp az=%0d el=%0d pol=%0d st=%0d, got az=%0d el=%0d pol=%0d st=%0d",
                     want.azimuth, want.elevation, want.polarization, want.status,
                     out_azimuth, out_elevation, out_polarization, out_status);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------- stimulus ----------------
  task automatic send_coord(coord_t ci, look_t want);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_station_long <= ci.station_long;
    in_station_east <= ci.station_east;
    in_station_lat <= ci.station_lat;
    in_station_north <= ci.station_north;
    in_sat_long <= ci.sat_long;
    in_sat_east <= ci.sat_east;
    in_vertical_pol <= ci.vertical_pol;
    do @(posedge clk); while (!in_ready);
    pending_looks.push_back(want);
  endtask

  function automatic coord_t random_coord();
    coord_t ci;
    longint s, t;
    int pick;
    pick = $urandom_range(99);
    ci.station_east = 1'($urandom_range(1));
    ci.station_north = 1'($urandom_range(1));
    ci.sat_east = 1'($urandom_range(1));
    ci.vertical_pol = 1'($urandom_range(1));
    if (pick < 10) begin
      // full field range, out-of-range values included
      ci.station_long = 18'($urandom);
      ci.station_lat = 17'($urandom);
      ci.sat_long = 18'($urandom);
    end else begin
      ci.station_long = 18'($urandom_range(180000));
      ci.station_lat = (pick < 15) ? 17'd0 : 17'($urandom_range(90000));
      ci.sat_long = 18'($urandom_range(180000));
      if (pick < 25) begin
        // satellite a quarter turn away
        s = ci.station_east ? longint'(ci.station_long) : -longint'(ci.station_long);
        t = s + ($urandom_range(1) ? 90000 : -90000);
        if (t > 180000) t -= 360000;
        if (t < -180000) t += 360000;
        ci.sat_east = (t >= 0);
        ci.sat_long = 18'((t >= 0) ? t : -t);
      end else if (pick < 32) begin
        ci.sat_long = ci.station_long;
        ci.sat_east = ci.station_east;
      end
    end
    return ci;
  endfunction

  initial begin
    row_t   rows[$];
    row_t   rw;
    look_t  want;
    int     pcts[4][2];
    atan_lut = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                 64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                 64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
                 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
                 64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
                 64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000};

    // long, east, lat, north, sat long, sat east, vertical | fixed az pol status
    rows.push_back('{'{18'd0, 1'b1, 17'd0, 1'b1, 18'd0, 1'b1, 1'b1},
                     1'b1, 19'd180000, 9'd45, 1'b1});
    rows.push_back('{'{18'd116000, 1'b1, 17'd0, 1'b0, 18'd87500, 1'b1, 1'b0},
                     1'b1, 19'd180000, 9'd315, 1'b1});
    rows.push_back('{'{18'd10000, 1'b1, 17'd40000, 1'b1, 18'd100000, 1'b1, 1'b1},
                     1'b1, 19'd180000, 9'd45, 1'b1});
    rows.push_back('{'{18'd45000, 1'b0, 17'd30000, 1'b0, 18'd45000, 1'b1, 1'b0},
                     1'b1, 19'd180000, 9'd315, 1'b1});
    rows.push_back('{'{18'd116400, 1'b1, 17'd39900, 1'b1, 18'd110500, 1'b1, 1'b1},
                     1'b0, '0, '0, 1'b0});
    rows.push_back('{'{18'd116400, 1'b1, 17'd39900, 1'b0, 18'd110500, 1'b1, 1'b0},
                     1'b0, '0, '0, 1'b0});
    rows.push_back('{'{18'd180000, 1'b1, 17'd90000, 1'b1, 18'd180000, 1'b0, 1'b1},
                     1'b0, '0, '0, 1'b0});
    rows.push_back('{'{18'd180000, 1'b0, 17'd90000, 1'b0, 18'd0, 1'b0, 1'b0},
                     1'b0, '0, '0, 1'b0});
    rows.push_back('{'{18'd1000, 1'b1, 17'd20000, 1'b1, 18'd1000, 1'b0, 1'b1},
                     1'b0, '0, '0, 1'b0});
    rows.push_back('{'{18'd0, 1'b0, 17'd50000, 1'b1, 18'd5000, 1'b1, 1'b0},
                     1'b0, '0, '0, 1'b0});
    rows.push_back('{'{18'd262143, 1'b1, 17'd131071, 1'b1, 18'd262143, 1'b0, 1'b1},
                     1'b0, '0, '0, 1'b0});
    rows.push_back('{'{18'd262143, 1'b0, 17'd131071, 1'b0, 18'd0, 1'b1, 1'b0},
                     1'b0, '0, '0, 1'b0});
    rows.push_back('{'{18'd100000, 1'b1, 17'd1, 1'b1, 18'd100000, 1'b1, 1'b1},
                     1'b0, '0, '0, 1'b0});
    rows.push_back('{'{18'd75000, 1'b0, 17'd60000, 1'b1, 18'd15000, 1'b0, 1'b0},
                     1'b0, '0, '0, 1'b0});
    rows.push_back('{'{18'd30000, 1'b1, 17'd89999, 1'b0, 18'd170000, 1'b0, 1'b1},
                     1'b0, '0, '0, 1'b0});

    pcts = '{'{0, 0}, '{79, 0}, '{0, 79}, '{25, 25}};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      rw = rows[i];
      want = predict_look(rw.c);
      if (rw.fixed) begin
        want.azimuth = rw.az;
        want.polarization = rw.pol;
        want.status = rw.st;
      end
      send_coord(rw.c, want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = pcts[ph][0];
      stall_pct = pcts[ph][1];
      for (int n = 0; n < 220; n++) begin
        coord_t ci;
        ci = random_coord();
        send_coord(ci, predict_look(ci));
      end
    end
    in_valid <= 1'b0;
    stall_pct = 0;

    while (pending_looks.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && pending_looks.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
